[rtl/kht_pkg.sv]
// Shared types, constants and helpers for the keyed hash table.
// Depends on nothing; every other file of the block imports it.
package kht_pkg;

  // Table geometry.
  localparam int BUCKET_BITS = 10;
  localparam int WAYS        = 4;
  localparam int NUM_BUCKETS = 1 << BUCKET_BITS;

  // Request queue between the front and the back part.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam int KEY_W = 64;
  localparam int VAL_W = 64;

  // Raw command codes as they arrive on the input bus.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_GET    = 2'd2;

  // Operation after classification by the front part.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_BAD    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_CMD   = 2'd3
  } status_t;

  // One classified request as it sits in the queue.
  typedef struct packed {
    op_t                    op;
    logic [BUCKET_BITS-1:0] bucket;
    logic [KEY_W-1:0]       key;
    logic [VAL_W-1:0]       value;
  } kht_req_t;

  // One result word.
  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] found_value;
    logic             replaced;
  } kht_rsp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } kht_fifo_stat_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } kht_back_stat_t;

  // Bucket of a key: the key folded with itself at 16-bit steps.
  function automatic logic [BUCKET_BITS-1:0] bucket_of(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] h;
    h = k ^ (k >> 16) ^ (k >> 32) ^ (k >> 48);
    return h[BUCKET_BITS-1:0];
  endfunction

endpackage

[rtl/kht_front.sv]
// Front part of the keyed hash table: classifies commands and hashes keys.
// Depends on kht_pkg.
module kht_front import kht_pkg::*; (
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [127:0]     s_tdata,   // key [63:0], new_value [127:64]
  input  logic [1:0]       s_tuser,   // command [1:0]
  input  kht_fifo_stat_t   fifo_stat,
  input  kht_back_stat_t   back_stat,
  output logic             push,
  output kht_req_t         push_req
);

  op_t op;

  always_comb begin
    unique case (s_tuser)
      CMD_INSERT: op = OP_INSERT;
      CMD_REMOVE: op = OP_REMOVE;
      CMD_GET:    op = OP_GET;
      default:    op = OP_BAD;
    endcase
  end

  // Nothing enters while the valid store is being swept after reset.
  assign s_tready = !rst && !back_stat.clearing && !fifo_stat.full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    push_req.op     = op;
    push_req.key    = s_tdata[KEY_W-1:0];
    push_req.value  = s_tdata[KEY_W+VAL_W-1:KEY_W];
    push_req.bucket = bucket_of(s_tdata[KEY_W-1:0]);
  end

endmodule

[rtl/kht_fifo.sv]
// Short request queue that decouples the front part from the back part.
// Depends on kht_pkg.
module kht_fifo import kht_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  kht_req_t       push_req,
  input  logic           pop,
  output kht_req_t       head,
  output kht_fifo_stat_t stat
);

  kht_req_t             slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
    return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_req;
  end

  assign head       = slots[rd_ptr];
  assign stat.full  = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

endmodule

[rtl/kht_back.sv]
// Back part of the keyed hash table: bucket memories, way compare and
// write-back, the post-reset sweep of the valid store, and the result register.
// Depends on kht_pkg.
module kht_back import kht_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  kht_fifo_stat_t fifo_stat,
  input  kht_req_t       head,
  output kht_back_stat_t stat,
  output logic           res_valid,
  input  logic           res_ready,
  output kht_rsp_t       res
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  logic [WAYS-1:0][KEY_W-1:0] key_mem [NUM_BUCKETS];
  logic [WAYS-1:0][VAL_W-1:0] val_mem [NUM_BUCKETS];
  logic [WAYS-1:0]            vld_mem [NUM_BUCKETS];

  state_t                     state;
  logic [BUCKET_BITS:0]       clr_cnt;
  logic                       clearing;
  logic                       pop;
  kht_req_t                   cur;
  logic [WAYS-1:0][KEY_W-1:0] key_rd;
  logic [WAYS-1:0][VAL_W-1:0] val_rd;
  logic [WAYS-1:0]            vld_rd;

  logic [WAYS-1:0]  match;
  logic [WAYS-1:0]  match_oh;
  logic [WAYS-1:0]  free;
  logic [WAYS-1:0]  free_oh;
  logic [VAL_W-1:0] match_value;
  logic [WAYS-1:0]  row_we;
  logic             key_we;
  logic             vld_we;
  logic [WAYS-1:0]  vld_row_next;
  kht_rsp_t         rsp_next;

  assign clearing = !clr_cnt[BUCKET_BITS];
  assign pop      = (state == S_IDLE) && !clearing && !fifo_stat.empty &&
                    (!res_valid || res_ready);
  assign stat.clearing = clearing;
  assign stat.pop      = pop;

  // Way compare; at most one valid way holds a key, lowest wins anyway.
  always_comb begin
    match_value = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = vld_rd[w] && (key_rd[w] == cur.key);
    end
    match_oh = match & (~match + 1'b1);
    free     = ~vld_rd;
    free_oh  = free & (~free + 1'b1);
    for (int w = 0; w < WAYS; w++) begin
      if (match_oh[w]) match_value = match_value | val_rd[w];
    end
  end

  always_comb begin
    row_we       = '0;
    key_we       = 1'b0;
    vld_we       = 1'b0;
    vld_row_next = vld_rd;
    rsp_next     = '{status: ST_OK, found_value: '0, replaced: 1'b0};
    unique case (cur.op)
      OP_INSERT: begin
        if (|match) begin
          row_we            = match_oh;
          rsp_next.replaced = 1'b1;
        end else if (|free) begin
          row_we       = free_oh;
          key_we       = 1'b1;
          vld_we       = 1'b1;
          vld_row_next = vld_rd | free_oh;
        end else begin
          rsp_next.status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (|match) begin
          vld_we       = 1'b1;
          vld_row_next = vld_rd & ~match_oh;
        end else begin
          rsp_next.status = ST_NOT_FOUND;
        end
      end
      OP_GET: begin
        if (|match) rsp_next.found_value = match_value;
        else        rsp_next.status      = ST_NOT_FOUND;
      end
      default: rsp_next.status = ST_BAD_CMD;
    endcase
  end

  // Key and value stores: one row read per item, at most one way written per item.
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      for (int w = 0; w < WAYS; w++) begin
        if (row_we[w]) begin
          if (key_we) key_mem[cur.bucket][w] <= cur.key;
          val_mem[cur.bucket][w] <= cur.value;
        end
      end
    end
    if (pop) begin
      key_rd <= key_mem[head.bucket];
      val_rd <= val_mem[head.bucket];
    end
  end

  // Valid store: swept to zero after reset, then read-modify-written.
  always_ff @(posedge clk) begin
    if (clearing) begin
      vld_mem[clr_cnt[BUCKET_BITS-1:0]] <= '0;
    end else if ((state == S_EXEC) && vld_we) begin
      vld_mem[cur.bucket] <= vld_row_next;
    end
    if (pop) vld_rd <= vld_mem[head.bucket];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clr_cnt   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (clearing) clr_cnt <= clr_cnt + 1'b1;
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            state <= S_EXEC;
            cur   <= head;
          end
        end
        S_EXEC: begin
          state     <= S_IDLE;
          res_valid <= 1'b1;
          res       <= rsp_next;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/keyed_hash_table.sv]
// Top level of the keyed hash table: front part, request queue, back part.
// Depends on kht_pkg, kht_front, kht_fifo and kht_back.
//
// A set-associative store of 64-bit keys and 64-bit values with 1024 buckets
// of 4 ways. Each input word carries a command (insert or replace, remove,
// get), a key and a value; each produces exactly one result word with a
// status, the found value of a successful get and a replaced flag, in order.
// The bucket is the key XOR-folded at 16-bit steps, low 10 bits. An insert
// into a full bucket is refused with status "bucket full". After reset the
// valid store is swept one bucket per cycle, so the block takes no input
// word until the sweep is done. In steady state the back part handles one
// word at a time: it reads the bucket row from synchronous memory, compares
// and writes it back in the next cycle, and the next row read waits for
// that write. A two-word queue between the front and back parts and a
// result register let input words be taken while a result is still waiting
// on the output side.
module keyed_hash_table import kht_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // key [63:0], new_value [127:64]
  input  logic [1:0]   s_tuser,   // command [1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata,   // found_value [63:0], replaced [64], zero [71:65]
  output logic [1:0]   m_tuser    // status [1:0]
);

  kht_fifo_stat_t fifo_stat;
  kht_back_stat_t back_stat;
  logic           push;
  kht_req_t       push_req;
  kht_req_t       head;
  kht_rsp_t       res;

  // Classify the command and hash the key on the way into the queue.
  kht_front u_front (
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .fifo_stat (fifo_stat),
    .back_stat (back_stat),
    .push      (push),
    .push_req  (push_req)
  );

  kht_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (back_stat.pop),
    .head     (head),
    .stat     (fifo_stat)
  );

  // Bucket read, way compare and write-back; result held until taken.
  kht_back u_back (
    .clk       (clk),
    .rst       (rst),
    .fifo_stat (fifo_stat),
    .head      (head),
    .stat      (back_stat),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tuser = res.status;
  assign m_tdata = {7'd0, res.replaced, res.found_value};

  // No word may be taken while the valid store is still being swept.
  assert property (@(posedge clk) disable iff (rst) back_stat.clearing |-> !s_tready)
    else $error("input word accepted during valid-store sweep");

  // The front part never pushes into a full queue.
  assert property (@(posedge clk) disable iff (rst) push |-> !fifo_stat.full)
    else $error("push into full request queue");

  // A new result appears only after its request has left the queue and been executed.
  assert property (@(posedge clk) disable iff (rst) $rose(m_tvalid) |-> $past(back_stat.pop, 2))
    else $error("result word without a matching queue pop");

endmodule

[verif/tb_keyed_hash_table.sv]
// Self-checking testbench for keyed_hash_table: directed and random command words,
// each result word checked against a behavioral model of the bucketed store.
// Depends on kht_pkg and the keyed_hash_table RTL.
`timescale 1ns / 100ps

module tb_keyed_hash_table;
  import kht_pkg::*;

  localparam int NUM_SLOTS    = NUM_BUCKETS * WAYS;
  // The raw command bus has one code the block must refuse.
  localparam logic [1:0] CMD_BAD = 2'd3;
  localparam int RANDOM_WORDS = 450;
  localparam int PHASES       = 4;
  localparam int HOT_BUCKETS  = 4;
  // More keys per hot bucket than ways, so that buckets run full.
  localparam int KEYS_PER_HOT = 6;
  localparam int HOT_KEYS     = HOT_BUCKETS * KEYS_PER_HOT;
  localparam int TAIL_CYCLES  = 20;
  // The slowest correct run: the clearing sweep after reset, then about 475 words
  // with the largest idle gaps on each side plus the block's own work. The limit
  // leaves a wide margin over that.
  localparam int CYCLE_LIMIT  = 200000;

  // Expected outcome of one command word.
  typedef struct {
    status_t     status;
    logic [63:0] found_value;
    logic        replaced;
  } lookup_result_t;

  // Scoreboard: keeps its own copy of the ways and the queue of results still due.
  class kv_scoreboard;
    bit             way_used[NUM_SLOTS];
    bit [63:0]      stored_key[NUM_SLOTS];
    bit [63:0]      stored_val[NUM_SLOTS];
    lookup_result_t result_q[$];
    int             errors;
    int             checked;

    // Bucket index: the key XOR-folded at 16-bit steps, low bits kept.
    static function int unsigned fold_index(logic [63:0] key);
      logic [63:0] folded;
      folded = key ^ {16'd0, key[63:16]} ^ {32'd0, key[63:32]} ^ {48'd0, key[63:48]};
      return int'(folded[BUCKET_BITS-1:0]);
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    // Apply one accepted command word to the model and queue its result.
    function void note_command(logic [1:0] cmd, logic [63:0] key, logic [63:0] value);
      int unsigned    row;
      int             hit;
      int             free;
      lookup_result_t r;
      row  = fold_index(key) * WAYS;
      hit  = -1;
      free = -1;
      for (int w = 0; w < WAYS; w++) begin
        if (way_used[row+w] && stored_key[row+w] == key && hit < 0) hit = w;
        if (!way_used[row+w] && free < 0) free = w;
      end
      r.status      = ST_OK;
      r.found_value = '0;
      r.replaced    = 1'b0;
      case (cmd)
        CMD_INSERT: begin
          if (hit >= 0) begin
            stored_val[row+hit] = value;
            r.replaced = 1'b1;
          end else if (free >= 0) begin
            // New keys land in the lowest-numbered free way.
            way_used[row+free]   = 1'b1;
            stored_key[row+free] = key;
            stored_val[row+free] = value;
          end else begin
            r.status = ST_FULL;
          end
        end
        CMD_REMOVE: begin
          if (hit >= 0) way_used[row+hit] = 1'b0;
          else r.status = ST_NOT_FOUND;
        end
        CMD_GET: begin
          if (hit >= 0) r.found_value = stored_val[row+hit];
          else r.status = ST_NOT_FOUND;
        end
        default: begin
          r.status = ST_BAD_CMD;
        end
      endcase
      result_q.push_back(r);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 200) $display("MISMATCH: %s", what);
    endtask

    // Compare one result word with the oldest outstanding expectation.
    task check_result(logic [1:0] status, logic [63:0] found, logic replaced);
      lookup_result_t e;
      if (result_q.size() == 0) begin
        report_mismatch($sformatf("result word with none due: status %0d found %h",
                                  status, found));
        return;
      end
      e = result_q.pop_front();
      if (status !== e.status || found !== e.found_value || replaced !== e.replaced)
        report_mismatch($sformatf("word %0d: status %0d/%0d found %h/%h replaced %b/%b",
                                  checked, status, e.status, found, e.found_value,
                                  replaced, e.replaced));
      checked++;
    endtask
  endclass

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata  = '0;   // key [63:0], new_value [127:64]
  logic [1:0]   s_tuser  = '0;   // command [1:0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;         // found_value [63:0], replaced [64], zero [71:65]
  logic [1:0]   m_tuser;         // status [1:0]

  kv_scoreboard sb = new();

  // Upper bounds of the idle cycles each side draws per word; changed per phase.
  int           send_idle_max = 9;
  int           recv_idle_max = 9;
  int           cycles        = 0;
  logic [63:0]  hot_keys[HOT_KEYS];

  keyed_hash_table DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_keyed_hash_table: FAIL");
      $finish;
    end
  end

  // Build a key whose fold lands in the given bucket: the upper bits stay random
  // and the low bucket bits are chosen to cancel the folded-in upper slices.
  function automatic logic [63:0] key_in_bucket(int unsigned bucket, logic [63:0] raw);
    logic [63:0] k;
    k = raw;
    k[BUCKET_BITS-1:0] = bucket[BUCKET_BITS-1:0] ^ k[16 +: BUCKET_BITS] ^
                         k[32 +: BUCKET_BITS] ^ k[48 +: BUCKET_BITS];
    return k;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one command word after a random gap and hold it until it is taken.
  // Valid is left high after the handshake so that back-to-back words never
  // lower and raise it within one time step.
  task automatic send_word(logic [1:0] cmd, logic [63:0] key, logic [63:0] value);
    int gap;
    gap = $urandom_range(send_idle_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {value, key};
    s_tuser  <= cmd;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    sb.note_command(cmd, key, value);
  endtask

  // Stop sending and wait until every result word due has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Pick a fresh set of crowded buckets and the keys that share them.
  task automatic refresh_hot_keys();
    int unsigned bucket;
    for (int b = 0; b < HOT_BUCKETS; b++) begin
      bucket = $urandom_range(NUM_BUCKETS - 1);
      for (int i = 0; i < KEYS_PER_HOT; i++)
        hot_keys[b*KEYS_PER_HOT + i] = key_in_bucket(bucket, rand64());
    end
  endtask

  // Mostly commands on crowded buckets, so that hits, replacements and full
  // buckets are common; some keys are fully random and mostly miss.
  task automatic send_random_word();
    int unsigned pick;
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [63:0] value;
    pick = $urandom_range(99);
    if (pick < 40)      cmd = CMD_INSERT;
    else if (pick < 60) cmd = CMD_REMOVE;
    else if (pick < 90) cmd = CMD_GET;
    else                cmd = CMD_BAD;
    if ($urandom_range(99) < 85) key = hot_keys[$urandom_range(HOT_KEYS - 1)];
    else key = rand64();
    case ($urandom_range(19))
      0:       value = '0;
      1:       value = '1;
      2:       value = {1'b1, 63'd0};
      3:       value = {1'b0, {63{1'b1}}};
      default: value = rand64();
    endcase
    send_word(cmd, key, value);
  endtask

  // Hand-picked words: extreme keys and values, every command, replacement,
  // removal, misses, the refused command and a bucket filled past its ways.
  task automatic run_directed();
    logic [63:0] key_min;
    logic [63:0] key_max;
    logic [63:0] crowd[5];
    int unsigned bucket;
    key_min = {1'b1, 63'd0};
    key_max = {1'b0, {63{1'b1}}};
    bucket  = $urandom_range(NUM_BUCKETS - 1);
    for (int i = 0; i < 5; i++) crowd[i] = key_in_bucket(bucket, rand64());

    send_word(CMD_GET,    64'd0, 64'd0);         // empty table: miss
    send_word(CMD_REMOVE, 64'd0, 64'd0);         // removing an absent key
    send_word(CMD_INSERT, 64'd0, key_max);
    send_word(CMD_GET,    64'd0, 64'd0);
    send_word(CMD_INSERT, 64'd0, key_min);       // overwrite of an existing key
    send_word(CMD_GET,    64'd0, '1);
    send_word(CMD_INSERT, '1, '1);
    send_word(CMD_GET,    '1, 64'd0);
    send_word(CMD_INSERT, key_min, 64'd0);
    send_word(CMD_INSERT, key_max, 64'h5555_5555_5555_5555);
    send_word(CMD_BAD,    '1, '1);               // refused, table unchanged
    send_word(CMD_GET,    '1, 64'd0);
    send_word(CMD_REMOVE, '1, 64'd0);
    send_word(CMD_GET,    '1, 64'd0);
    send_word(CMD_REMOVE, '1, 64'd0);
    // Fill one bucket, then push one key too many into it.
    for (int i = 0; i < WAYS; i++) send_word(CMD_INSERT, crowd[i], rand64());
    send_word(CMD_INSERT, crowd[4], rand64());   // bucket full
    send_word(CMD_INSERT, crowd[2], rand64());   // full bucket, but a replacement
    send_word(CMD_REMOVE, crowd[1], 64'd0);
    send_word(CMD_INSERT, crowd[4], rand64());   // reuses the freed middle way
    send_word(CMD_GET,    crowd[4], 64'd0);
    send_word(CMD_GET,    crowd[1], 64'd0);
  endtask

  // Result side: random back-pressure per word, check every accepted result.
  initial begin : result_sink
    int stall;
    forever begin
      stall = $urandom_range(recv_idle_max);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (rst || m_tvalid !== 1'b1) @(posedge clk);
      sb.check_result(m_tuser, m_tdata[63:0], m_tdata[64]);
    end
  end

  // Stimulus: reset, the directed words, then random phases with different
  // idle patterns on the two sides. Each phase ends by draining, so the sender
  // sits idle several times until no result is outstanding.
  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // The block sweeps its valid marks after reset; the first send simply
    // waits on ready through that.
    run_directed();
    wait_drained();
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin send_idle_max = 9; recv_idle_max = 9; end
        1:       begin send_idle_max = 0; recv_idle_max = 0; end
        2:       begin send_idle_max = 0; recv_idle_max = 9; end
        default: begin send_idle_max = 9; recv_idle_max = 0; end
      endcase
      refresh_hot_keys();
      repeat ((RANDOM_WORDS + PHASES - 1) / PHASES) send_random_word();
      wait_drained();
    end
    // Any stray result word after this point is flagged by the scoreboard.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_keyed_hash_table: PASS");
    end else begin
      $display("tb_keyed_hash_table: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/kht_pkg.sv
rtl/kht_front.sv
rtl/kht_fifo.sv
rtl/kht_back.sv
rtl/keyed_hash_table.sv
verif/tb_keyed_hash_table.sv
